FILE: hdl/hbtm_pkg.sv
// ----------------------------------------------------------------------------
// Heartbeat timeout monitor package
// Shared types and constants for the node cells and the top level.
// ----------------------------------------------------------------------------
package hbtm_pkg;

  localparam int unsigned CNT_W    = 3;
  localparam int unsigned NODE_W   = 2;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned MASK_W   = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [TIME_W-1:0]    TMO_RESET    = 32'd1000;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT0 = 3'd1;

  typedef enum logic {
    KIND_HB    = 1'b0,
    KIND_CHECK = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [NODE_W-1:0]  node;
    logic [TIME_W-1:0]  now;
    logic [BYTE_W-1:0]  seq;
    logic [BYTE_W-1:0]  pst;
    logic [MASK_W-1:0]  alive;
    logic [MASK_W-1:0]  lost;
    logic [BYTE_W-1:0]  nseq;
    logic [BYTE_W-1:0]  npst;
    logic               ign;
  } probe_t;

  typedef struct packed {
    logic [CNT_W-1:0]     count;
    logic                 tmo_we;
    logic                 clr;
    logic [TIME_W-1:0]    tmo_data;
  } cell_cfg_t;

endpackage

FILE: hdl/hbtm_cell.sv
// ----------------------------------------------------------------------------
// Heartbeat timeout monitor node cell
// Holds one node's record and timeout, and updates the passing transfer.
// ----------------------------------------------------------------------------
module hbtm_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  hbtm_pkg::probe_t    probe_i,
  input  hbtm_pkg::cell_cfg_t cfg_i,
  output logic                vld_o,
  output hbtm_pkg::probe_t    probe_o
);

  localparam logic [hbtm_pkg::CNT_W-1:0]  CellCnt  = INDEX[hbtm_pkg::CNT_W-1:0];
  localparam logic [hbtm_pkg::NODE_W-1:0] CellNode = INDEX[hbtm_pkg::NODE_W-1:0];
  localparam logic [hbtm_pkg::MASK_W-1:0] CellBit  =
    hbtm_pkg::MASK_W'(1) << INDEX;

  logic [hbtm_pkg::TIME_W-1:0] last_q, last_d, tmo_q, elapsed;
  logic [hbtm_pkg::BYTE_W-1:0] seq_q, seq_d, pst_q, pst_d;
  logic                        seen_q, seen_d, alive_q, alive_d;
  logic                        active, hit, expired;
  logic                        vld_q;
  hbtm_pkg::probe_t            probe_q, probe_d;

  assign active  = CellCnt < cfg_i.count;
  assign hit     = probe_i.node == CellNode;
  assign elapsed = probe_i.now - last_q;
  assign expired = seen_q && (elapsed > tmo_q);

  always_comb begin
    last_d  = last_q;
    seq_d   = seq_q;
    pst_d   = pst_q;
    seen_d  = seen_q;
    alive_d = alive_q;
    probe_d = probe_i;
    if (vld_i && active) begin
      if (probe_i.kind == hbtm_pkg::KIND_HB) begin
        if (hit) begin
          last_d  = probe_i.now;
          seq_d   = probe_i.seq;
          pst_d   = probe_i.pst;
          seen_d  = 1'b1;
          alive_d = 1'b1;
        end
      end else if (expired) begin
        alive_d = 1'b0;
        if (alive_q) begin
          probe_d.lost = probe_i.lost | CellBit;
        end
      end
    end
    if (active && alive_d) begin
      probe_d.alive = probe_i.alive | CellBit;
    end
    if (hit) begin
      probe_d.nseq = seq_d;
      probe_d.npst = pst_d;
    end
    if (cfg_i.clr) begin
      last_d  = '0;
      seq_d   = '0;
      pst_d   = '0;
      seen_d  = 1'b0;
      alive_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      seq_q   <= '0;
      pst_q   <= '0;
      seen_q  <= 1'b0;
      alive_q <= 1'b0;
      tmo_q   <= hbtm_pkg::TMO_RESET;
      vld_q   <= 1'b0;
    end else begin
      last_q  <= last_d;
      seq_q   <= seq_d;
      pst_q   <= pst_d;
      seen_q  <= seen_d;
      alive_q <= alive_d;
      vld_q   <= vld_i;
      if (cfg_i.tmo_we) begin
        tmo_q <= cfg_i.tmo_data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      probe_q <= probe_d;
    end
  end

  assign vld_o   = vld_q;
  assign probe_o = probe_q;

endmodule

FILE: hdl/heartbeat_timeout_monitor.sv
// ----------------------------------------------------------------------------
// Heartbeat timeout monitor
// Watchdog bank for up to NODES peers, built as a chain of node cells.
// ----------------------------------------------------------------------------
// Each transfer walks the chain of NODES cells, one cell per cycle; each cell
// applies the heartbeat or timeout check to its own node record and adds its
// bits to the result. The result is held in the last cell until it is
// taken, and the next input is accepted no earlier than the cycle in which
// the result is taken, so only one transfer is in the chain at a time.
// Configuration writes must only be issued while the block is idle.
module heartbeat_timeout_monitor #(
  parameter int unsigned NODES = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [hbtm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [hbtm_pkg::CFG_DAT_W-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 kind_i,
  input  logic [hbtm_pkg::NODE_W-1:0]          node_i,
  input  logic [hbtm_pkg::TIME_W-1:0]          now_ticks_i,
  input  logic [hbtm_pkg::BYTE_W-1:0]          seq_in_i,
  input  logic [hbtm_pkg::BYTE_W-1:0]          peer_state_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [hbtm_pkg::MASK_W-1:0]          alive_mask_o,
  output logic [hbtm_pkg::MASK_W-1:0]          lost_mask_o,
  output logic [hbtm_pkg::BYTE_W-1:0]          node_sequence_o,
  output logic [hbtm_pkg::BYTE_W-1:0]          node_peer_state_o,
  output logic                                 ignored_o
);

  localparam logic [hbtm_pkg::CNT_W-1:0] MaxCnt = NODES[hbtm_pkg::CNT_W-1:0];

  logic [hbtm_pkg::CNT_W-1:0] active_q, eff_cnt, new_cnt;
  logic                       busy_q, out_valid_q;
  logic                       in_fire, out_fire;
  logic [NODES:0]             vld;
  hbtm_pkg::probe_t           probe [NODES+1];
  hbtm_pkg::cell_cfg_t        cell_cfg [NODES];

  assign eff_cnt = (active_q > MaxCnt) ? MaxCnt : active_q;
  assign new_cnt = (cfg_data_i[hbtm_pkg::CNT_W-1:0] > MaxCnt) ? MaxCnt
                                                               : cfg_data_i[hbtm_pkg::CNT_W-1:0];

  assign out_fire   = out_valid_q && out_ready_i;
  assign in_ready_o = !busy_q || out_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    probe[0]       = '0;
    probe[0].kind  = hbtm_pkg::kind_e'(kind_i);
    probe[0].node  = node_i;
    probe[0].now   = now_ticks_i;
    probe[0].seq   = seq_in_i;
    probe[0].pst   = peer_state_in_i;
    probe[0].ign   = (kind_i == hbtm_pkg::KIND_HB) &&
                     ({1'b0, node_i} >= eff_cnt);
  end
  assign vld[0] = in_fire;

  for (genvar i = 0; i < NODES; i++) begin : g_cell
    localparam logic [hbtm_pkg::CNT_W-1:0] Idx = hbtm_pkg::CNT_W'(i);

    always_comb begin
      cell_cfg[i].count    = eff_cnt;
      cell_cfg[i].tmo_data = cfg_data_i[hbtm_pkg::TIME_W-1:0];
      cell_cfg[i].tmo_we   = cfg_we_i && (cfg_idx_i == hbtm_pkg::REG_TIMEOUT0 + Idx);
      cell_cfg[i].clr      = cfg_we_i && (cfg_idx_i == hbtm_pkg::REG_ACTIVE) &&
                             (Idx >= eff_cnt) && (Idx < new_cnt);
    end

    hbtm_cell #(
      .INDEX(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld[i]),
      .probe_i(probe[i]),
      .cfg_i  (cell_cfg[i]),
      .vld_o  (vld[i+1]),
      .probe_o(probe[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == hbtm_pkg::REG_ACTIVE)) begin
        active_q <= cfg_data_i[hbtm_pkg::CNT_W-1:0];
      end
      if (in_fire) begin
        busy_q <= 1'b1;
      end else if (out_fire) begin
        busy_q <= 1'b0;
      end
      if (vld[NODES]) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign alive_mask_o      = probe[NODES].alive;
  assign lost_mask_o       = probe[NODES].lost;
  assign node_sequence_o   = probe[NODES].nseq;
  assign node_peer_state_o = probe[NODES].npst;
  assign ignored_o         = probe[NODES].ign;

  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(vld))
    else $error("more than one transfer in the cell chain");

  a_no_accept_midway : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> (vld[NODES:1] == '0))
    else $error("input taken while the chain is still working");

  a_lost_not_alive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((lost_mask_o & alive_mask_o) == '0))
    else $error("a node is reported both lost and alive");

  a_ignored_no_loss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ignored_o) |-> (lost_mask_o == '0))
    else $error("an ignored heartbeat reports lost nodes");

endmodule
